// ----- design/radio_noise_degrader_assert.svh -----
// assertion helpers used by the degrader design file
`ifndef RADIO_NOISE_DEGRADER_ASSERT_SVH
`define RADIO_NOISE_DEGRADER_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define RND_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define RND_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- design/rnd_pkg.sv -----
package rnd_pkg;

	localparam int MAX_FRAMES_DEF = 512;

	// configuration register indexes
	localparam logic [1:0] CFG_GAIN = 2'd0;
	localparam logic [1:0] CFG_SEED = 2'd1;

	localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

	// ceil(2^35 / 25), exact for 32-bit dividends
	localparam logic [31:0] RECIP_25 = 32'd1374389535;

	localparam logic [15:0] NOISE_OFFSET = 16'd16384;
	localparam logic [17:0] MIX_FULL = 18'd81920;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DGO,
		S_DIV,
		S_DMUL,
		S_DFOL,
		S_P1,
		S_P2,
		S_P3,
		S_P4,
		S_P5,
		S_P6,
		S_OUT
	} rnd_state_t;

	// one galois step
	function automatic logic [31:0] lfsr_step(input logic [31:0] s);
		lfsr_step = (s >> 1) ^ (s[0] ? LFSR_TAPS : 32'd0);
	endfunction

endpackage

// ----- design/rnd_div.sv -----
// restoring divider, one quotient bit per cycle
module rnd_div #(
	parameter int EW = 40,
	parameter int FW = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [EW-1:0] dividend,
	input  logic [FW-1:0] divisor,
	output logic          done,
	output logic [EW-1:0] quotient
);

	localparam int CW = $clog2(EW + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [FW-1:0] rem_q;
	logic [EW-1:0] quo_q;
	logic [FW:0]   rem_sh;
	logic [FW:0]   rem_sub;
	logic          bit_ok;

	// trial subtract
	always_comb begin
		rem_sh  = {rem_q, quo_q[EW-1]};
		rem_sub = rem_sh - {1'b0, divisor};
		bit_ok  = rem_sh >= {1'b0, divisor};
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(EW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CW'(1);
			done_q <= cnt_q == CW'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[EW-2:0], bit_ok};
			rem_q <= bit_ok ? rem_sub[FW-1:0] : rem_sh[FW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- design/radio_noise_degrader.sv -----
// Radio-style degrader for blocks of Q1.15 samples. A push writes the sample
// into the block memory unless a block is draining or the memory is full; a push
// marked last with a nonzero gain closes the block through the mean-square
// divider, then updates the follower and noise. A pull that finds a sample goes
// through one block-memory read, six arithmetic stages (noise product, quantize,
// two products, mix, reciprocal divide by 409600, saturate) and the result beat;
// at zero gain it skips the arithmetic, and a pull that finds nothing goes
// straight to the result beat.
// The block memory is never cleared: only entries of the current block are read.
`include "radio_noise_degrader_assert.svh"

module radio_noise_degrader #(
	parameter int MAX_FRAMES = rnd_pkg::MAX_FRAMES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic signed [15:0] sample_in,
	input  logic               channel,
	input  logic               is_last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sample_out,
	output logic               last_out,
	output logic               empty_res,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int AW = $clog2(MAX_FRAMES);
	localparam int FW = $clog2(MAX_FRAMES + 1);
	localparam int EW = 31 + AW;

	rnd_pkg::rnd_state_t state_q, state_d;

	logic signed [15:0] mem [MAX_FRAMES];
	logic signed [15:0] rd_q;
	logic               mem_we, mem_re;

	logic [FW-1:0]  fill_q, rdidx_q;
	logic [EW-1:0]  energy_q;
	logic [31:0]    follow_q [2];
	logic [31:0]    lfsr_q;
	logic signed [15:0] held_q;
	logic [7:0]     hold_q;
	logic           draining_q, lastch_q;
	logic [15:0]    gain_q;

	logic push_acc, pull_acc, cfg_acc, div_start, div_done, pull_hit, fin;
	logic [EW-1:0] div_quo;

	logic [31:0] d1, d2;
	logic signed [15:0] noise_new;
	logic [7:0]  hold_new;
	logic signed [31:0] sq;

	// result holding
	logic signed [15:0] res_sample_q;
	logic               res_empty_q, fin_q;

	// pipeline
	logic signed [15:0] n_s1, x_s2, x_s3;
	logic [31:0]        follow_s1;
	logic signed [49:0] t_s2;
	logic signed [15:0] q_s3;
	logic signed [32:0] p1_s4;
	logic signed [33:0] p2_s4;
	logic [31:0]        m2_s5;
	logic               neg_s5, neg_s6;
	logic [28:0]        quo_s6;
	logic [46:0]        mprod_q;

	logic signed [48:0] nf;
	logic signed [56:0] t40, qv;
	logic signed [32:0] p1;
	logic signed [33:0] p2;
	logic signed [45:0] num, mag;
	logic [63:0]        rprod;
	logic [30:0]        vol;
	logic [32:0]        fsum;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign push_acc  = in_valid && in_ready && !operation;
	assign pull_acc  = in_valid && in_ready && operation;
	assign pull_hit  = draining_q && (rdidx_q < fill_q);
	assign fin       = (rdidx_q + FW'(1)) >= fill_q;
	assign mem_we    = push_acc && !draining_q && (fill_q < FW'(MAX_FRAMES));
	assign mem_re    = pull_acc && pull_hit;

	// next state and strobes
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		case (state_q)
			rnd_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (push_acc && !draining_q && is_last && gain_q != '0) begin
					state_d = rnd_pkg::S_DGO;
				end else if (pull_acc) begin
					state_d = pull_hit ? rnd_pkg::S_P1 : rnd_pkg::S_OUT;
				end
			end
			rnd_pkg::S_DGO: begin
				div_start = 1'b1;
				state_d   = rnd_pkg::S_DIV;
			end
			rnd_pkg::S_DIV:  if (div_done) state_d = rnd_pkg::S_DMUL;
			rnd_pkg::S_DMUL: state_d = rnd_pkg::S_DFOL;
			rnd_pkg::S_DFOL: state_d = rnd_pkg::S_IDLE;
			rnd_pkg::S_P1:   state_d = (gain_q == '0) ? rnd_pkg::S_OUT : rnd_pkg::S_P2;
			rnd_pkg::S_P2:   state_d = rnd_pkg::S_P3;
			rnd_pkg::S_P3:   state_d = rnd_pkg::S_P4;
			rnd_pkg::S_P4:   state_d = rnd_pkg::S_P5;
			rnd_pkg::S_P5:   state_d = rnd_pkg::S_P6;
			rnd_pkg::S_P6:   state_d = rnd_pkg::S_OUT;
			rnd_pkg::S_OUT:  if (!out_valid || out_ready) state_d = rnd_pkg::S_IDLE;
			default:         state_d = rnd_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rnd_pkg::S_IDLE;
		else         state_q <= state_d;
	end

	// block memory
	always_ff @(posedge clk) begin
		if (mem_we) mem[fill_q[AW-1:0]] <= sample_in;
		if (mem_re) rd_q <= mem[rdidx_q[AW-1:0]];
	end

	// mean-square divider
	rnd_div #(.EW(EW), .FW(FW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (energy_q),
		.divisor  (fill_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// noise redraw, two lfsr steps
	always_comb begin
		d1        = rnd_pkg::lfsr_step(lfsr_q);
		d2        = rnd_pkg::lfsr_step(d1);
		noise_new = $signed(16'(d1[14:0]) - rnd_pkg::NOISE_OFFSET);
		hold_new  = {1'b0, d2[6:0]} + 8'd1;
		sq        = sample_in * sample_in;
		vol       = mprod_q[46:16];
		fsum      = {1'b0, follow_q[lastch_q]} + 33'(vol);
	end

	// arithmetic per stage
	always_comb begin
		nf    = n_s1 * $signed({1'b0, follow_s1});
		t40   = (57'(t_s2) <<< 5) + (57'(t_s2) <<< 3);
		qv    = t40[56] ? ((t40 + 57'((57'd1 << 40) - 57'd1)) >>> 40) : (t40 >>> 40);
		p1    = q_s3 * $signed({1'b0, gain_q});
		p2    = x_s3 * $signed(rnd_pkg::MIX_FULL - {2'b0, gain_q});
		num   = (46'(p1_s4) <<< 12) + (46'(p2_s4) <<< 2) + 46'(p2_s4);
		mag   = num[45] ? -num : num;
		rprod = m2_s5 * rnd_pkg::RECIP_25;
	end

	// block control and follower state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rdidx_q     <= '0;
			energy_q    <= '0;
			follow_q[0] <= '0;
			follow_q[1] <= '0;
			lfsr_q      <= 32'd1;
			held_q      <= '0;
			hold_q      <= '0;
			draining_q  <= 1'b0;
			lastch_q    <= 1'b0;
			gain_q      <= '0;
		end else begin
			if (cfg_acc) begin
				case (cfg_index)
					rnd_pkg::CFG_GAIN: gain_q <= cfg_data[15:0];
					rnd_pkg::CFG_SEED: lfsr_q <= (cfg_data != '0) ? cfg_data : 32'd1;
					default: ;
				endcase
			end
			// push beat
			if (push_acc && !draining_q) begin
				if (fill_q < FW'(MAX_FRAMES)) begin
					energy_q <= energy_q + EW'(sq[30:0]);
					fill_q   <= fill_q + FW'(1);
				end
				if (is_last) begin
					lastch_q <= channel;
					rdidx_q  <= '0;
					if (gain_q == '0) draining_q <= 1'b1;
				end
			end
			// block close with gain
			if (state_q == rnd_pkg::S_DFOL) begin
				follow_q[lastch_q] <= fsum[32:1];
				held_q     <= noise_new;
				hold_q     <= hold_new;
				lfsr_q     <= d2;
				draining_q <= 1'b1;
			end
			// pull beat that finds a sample
			if (mem_re) begin
				if (fin) begin
					fill_q     <= '0;
					rdidx_q    <= '0;
					energy_q   <= '0;
					draining_q <= 1'b0;
				end else begin
					rdidx_q <= rdidx_q + FW'(1);
				end
				if (gain_q != '0) begin
					if (hold_q == '0) begin
						held_q <= noise_new;
						hold_q <= hold_new;
						lfsr_q <= d2;
					end else begin
						hold_q <= hold_q - 8'd1;
					end
				end
			end
		end
	end

	// pipeline and result registers
	always_ff @(posedge clk) begin
		if (state_q == rnd_pkg::S_DMUL) mprod_q <= div_quo[30:0] * gain_q;
		if (pull_acc) begin
			fin_q        <= fin && pull_hit;
			res_empty_q  <= !pull_hit;
			res_sample_q <= '0;
			n_s1         <= (hold_q == '0) ? noise_new : held_q;
			follow_s1    <= follow_q[lastch_q];
		end
		case (state_q)
			rnd_pkg::S_P1: begin
				x_s2         <= rd_q;
				t_s2         <= (50'(rd_q) <<< 25) + 50'(nf);
				res_sample_q <= rd_q;
			end
			rnd_pkg::S_P2: begin
				q_s3 <= qv[15:0];
				x_s3 <= x_s2;
			end
			rnd_pkg::S_P3: begin
				p1_s4 <= p1;
				p2_s4 <= p2;
			end
			rnd_pkg::S_P4: begin
				m2_s5  <= mag[45:14];
				neg_s5 <= num[45];
			end
			rnd_pkg::S_P5: begin
				quo_s6 <= rprod[63:35];
				neg_s6 <= neg_s5;
			end
			rnd_pkg::S_P6: begin
				if (!neg_s6) begin
					res_sample_q <= (quo_s6 > 29'd32767) ? 16'sd32767 : $signed(quo_s6[15:0]);
				end else begin
					res_sample_q <= (quo_s6 > 29'd32768) ? -16'sd32768 : -$signed(quo_s6[15:0]);
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == rnd_pkg::S_OUT && (!out_valid || out_ready)) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rnd_pkg::S_OUT && (!out_valid || out_ready)) begin
			sample_out <= res_sample_q;
			last_out   <= fin_q;
			empty_res  <= res_empty_q;
		end
	end

	`RND_ASSERT_ALWAYS(a_fill_bound, fill_q <= FW'(MAX_FRAMES), "fill count past store depth")
	`RND_ASSERT_IMPL(a_drain_index, draining_q, rdidx_q < fill_q, "drain index not below fill")
	`RND_ASSERT_IMPL(a_div_state, div_done, state_q == rnd_pkg::S_DIV, "divider done outside wait")
	`RND_ASSERT_ALWAYS(a_hold_bound, hold_q <= 8'd128, "hold length out of range")

endmodule

// ----- dv/radio_noise_degrader_tb.sv -----
module radio_noise_degrader_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAMES = rnd_pkg::MAX_FRAMES_DEF;
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 120;
	localparam int RANDOM_ITEMS = 350;
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_PULL = 1'b1;

	typedef struct {
		logic signed [15:0] sample;
		logic last;
		logic empty;
	} beat_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic operation;
	logic signed [15:0] sample_in;
	logic channel;
	logic is_last;
	logic out_valid;
	logic out_ready;
	logic signed [15:0] sample_out;
	logic last_out;
	logic empty_res;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	// degrader image kept by the testbench
	logic [15:0] gain_reg;
	logic [31:0] seed_reg;
	logic signed [15:0] blk_mem [FRAMES];
	int fill_cnt;
	int rd_idx;
	longint unsigned energy_acc;
	logic [31:0] level_q26 [2];
	logic [31:0] lfsr_q;
	int noise_q14;
	int hold_cnt;
	bit draining;
	logic close_ch;

	beat_t pending_beats[$];
	int err_count;
	int items_sent;
	bit idle_en;
	int stall_cnt;

	radio_noise_degrader u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .sample_in(sample_in), .channel(channel), .is_last(is_last),
		.out_valid(out_valid), .out_ready(out_ready),
		.sample_out(sample_out), .last_out(last_out), .empty_res(empty_res),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// noise generator draw
	function automatic logic [31:0] lfsr_next();
		lfsr_q = (lfsr_q >> 1) ^ (lfsr_q[0] ? 32'h8020_0003 : 32'd0);
		return lfsr_q;
	endfunction

	function automatic void redraw_noise();
		noise_q14 = int'(lfsr_next() & 32'h7FFF) - 16384;
		hold_cnt = int'(lfsr_next() & 32'd127) + 1;
	endfunction

	function automatic void reset_image();
		gain_reg = '0;
		seed_reg = 32'd1;
		fill_cnt = 0;
		rd_idx = 0;
		energy_acc = 0;
		level_q26[0] = '0;
		level_q26[1] = '0;
		lfsr_q = 32'd1;
		noise_q14 = 0;
		hold_cnt = 0;
		draining = 1'b0;
		close_ch = 1'b0;
	endfunction

	// degraded sample for one pull
	function automatic logic signed [15:0] degrade(input logic signed [15:0] x);
		longint g, t, q, num, res;
		g = longint'(gain_reg);
		if (g == 0)
			return x;
		if (hold_cnt == 0)
			redraw_noise();
		else
			hold_cnt--;
		t = longint'(x) * 64'sd33554432 + longint'(noise_q14) * longint'({32'd0, level_q26[close_ch]});
		q = (t * 40) / 64'sd1099511627776;
		num = q * g * 4096 + 5 * longint'(x) * (81920 - g);
		res = num / 409600;
		if (res > 32767) res = 32767;
		if (res < -32768) res = -32768;
		return res[15:0];
	endfunction

	// apply one accepted input beat, queue the result it causes
	function automatic void predict_beat(input logic op, input logic signed [15:0] x,
			input logic ch, input logic lst);
		beat_t b;
		longint unsigned mean, vol, f;
		if (op == OP_PUSH) begin
			if (draining)
				return;
			if (fill_cnt < FRAMES) begin
				blk_mem[fill_cnt] = x;
				energy_acc += longint'(x) * longint'(x);
				fill_cnt++;
			end
			if (lst) begin
				close_ch = ch;
				draining = 1'b1;
				rd_idx = 0;
				if (gain_reg != 0 && fill_cnt != 0) begin
					mean = energy_acc / longint'(fill_cnt);
					vol = (mean * gain_reg) >> 16;
					f = (longint'(level_q26[ch]) + vol) >> 1;
					level_q26[ch] = f[31:0];
					redraw_noise();
				end
			end
			return;
		end
		if (!draining || rd_idx >= fill_cnt) begin
			b.sample = '0;
			b.last = 1'b0;
			b.empty = 1'b1;
		end else begin
			b.sample = degrade(blk_mem[rd_idx]);
			b.last = (rd_idx + 1 >= fill_cnt);
			b.empty = 1'b0;
			rd_idx++;
			if (b.last) begin
				fill_cnt = 0;
				rd_idx = 0;
				energy_acc = 0;
				draining = 1'b0;
			end
		end
		pending_beats.push_back(b);
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch @%0t: %s", $realtime, what);
		err_count++;
	endtask

	// input and config monitor feeding the image
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			predict_beat(operation, sample_in, channel, is_last);
		if (arst_n && cfg_valid && cfg_ready) begin
			if (cfg_index == rnd_pkg::CFG_GAIN)
				gain_reg = cfg_data[15:0];
			else if (cfg_index == rnd_pkg::CFG_SEED) begin
				seed_reg = cfg_data;
				lfsr_q = (cfg_data == 0) ? 32'd1 : cfg_data;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		beat_t b;
		if (arst_n && out_valid && out_ready) begin
			if (pending_beats.size() == 0)
				report_mismatch("result beat with nothing expected");
			else begin
				b = pending_beats.pop_front();
				if (sample_out !== b.sample)
					report_mismatch($sformatf("sample_out %0d want %0d", sample_out, b.sample));
				if (last_out !== b.last)
					report_mismatch($sformatf("last_out %0b want %0b", last_out, b.last));
				if (empty_res !== b.empty)
					report_mismatch($sformatf("empty_res %0b want %0b", empty_res, b.empty));
			end
		end
	end

	// receiver backpressure
	always @(posedge clk) begin
		if (arst_n)
			out_ready <= !(idle_en && $urandom_range(99) < 6);
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_beat(input logic op, input logic signed [15:0] x,
			input logic ch, input logic lst);
		while (idle_en && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		sample_in <= x;
		channel <= ch;
		is_last <= lst;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// wait for every result, then for the block-close divider to settle
	task automatic wait_settled();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			3: return 16'shFFFF;
			default: return $urandom();
		endcase
	endfunction

	// push a block of len samples, then pull it back, with some noise beats when noisy is set
	task automatic run_block(input int len, input logic ch, input bit noisy);
		for (int i = 0; i < len; i++)
			send_beat(OP_PUSH, rand_sample(), ch, i == len - 1);
		for (int i = 0; i < len; i++) begin
			if (noisy && $urandom_range(99) < 5)
				send_beat(OP_PUSH, rand_sample(), $urandom(), $urandom());
			if (noisy && $urandom_range(199) == 0)
				wait_settled();
			send_beat(OP_PULL, $urandom(), $urandom(), $urandom());
		end
	endtask

	task automatic test_directed();
		// pass-through at zero gain, extremes and empty pulls
		send_beat(OP_PULL, 16'sh7FFF, 1'b1, 1'b1);
		send_beat(OP_PUSH, 16'sh8000, 1'b0, 1'b0);
		send_beat(OP_PUSH, 16'sh7FFF, 1'b0, 1'b0);
		send_beat(OP_PUSH, 16'sh0000, 1'b0, 1'b1);
		send_beat(OP_PUSH, 16'sh1234, 1'b1, 1'b1);
		for (int i = 0; i < 4; i++)
			send_beat(OP_PULL, 16'sh0000, 1'b0, 1'b0);
		wait_settled();
		// full gain on both channels
		write_reg(rnd_pkg::CFG_GAIN, 32'h0000_FFFF);
		write_reg(rnd_pkg::CFG_SEED, 32'hFFFF_FFFF);
		run_block(3, 1'b1, 1'b0);
		run_block(2, 1'b0, 1'b0);
		// single-sample block
		run_block(1, 1'b1, 1'b0);
		wait_settled();
	endtask

	task automatic test_full_store();
		write_reg(rnd_pkg::CFG_GAIN, 32'h0000_1000);
		run_block(FRAMES + 3, $urandom(), 1'b0);
		wait_settled();
	endtask

	task automatic test_random();
		int len;
		int start;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			if ($urandom_range(7) == 0) begin
				wait_settled();
				case ($urandom_range(3))
					0: write_reg(rnd_pkg::CFG_GAIN, 32'd0);
					1: write_reg(rnd_pkg::CFG_GAIN, 32'hFFFF);
					default: write_reg(rnd_pkg::CFG_GAIN, $urandom_range(65535));
				endcase
				if ($urandom_range(1))
					write_reg(rnd_pkg::CFG_SEED, ($urandom_range(3) == 0) ? 32'd1 :
						($urandom() | 32'd1));
			end
			if ($urandom_range(9) == 0)
				send_beat(OP_PULL, $urandom(), $urandom(), $urandom());
			len = ($urandom_range(19) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
			idle_en = (items_sent - start < 100 || items_sent - start > 250);
			run_block(len, $urandom(), 1'b1);
		end
		idle_en = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = 1'b0;
		sample_in = '0;
		channel = 1'b0;
		is_last = 1'b0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		err_count = 0;
		items_sent = 0;
		idle_en = 1'b1;
		reset_image();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_store();
		test_random();
		wait_settled();
		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+design
design/rnd_pkg.sv
design/rnd_div.sv
design/radio_noise_degrader.sv
dv/radio_noise_degrader_tb.sv
